@@ src/tmef_pkg.sv @@
// Shared types and constants for the n/3 majority element finder.
// Used by tmef_entry, tmef_cell and third_majority_element_finder_core.
package tmef_pkg;

    localparam int MAX_ITEMS_DEF = 1024;
    localparam int DATA_W        = 32;

    // What travels from one cell to the next in each cycle: at most one item
    // and at most one end-of-set request that collects the result.
    typedef struct packed {
        logic              item_vld;
        logic [DATA_W-1:0] item_value;
        logic              tok_vld;
        logic              tok_found;
        logic              tok_ovf;
        logic [DATA_W-1:0] tok_value;
    } t_link;

endpackage

@@ src/third_majority_element_finder_core.sv @@
// Top level of the n/3 majority element finder: entry stage, row of cells,
// output register. Depends on tmef_pkg, tmef_entry and tmef_cell.
//
// Streams a set of signed 32-bit values (tlast on the final one) and returns
// one result per set: whether some value occurs more than floor(n/3) times
// and, if several do, the one seen first. An item is taken every cycle the
// output does not stall; it moves down a row of MAX_ITEMS match-and-count
// cells, one cell per cycle, and stops in the cell that holds its value or in
// the first free one. The end-of-set request enters with the last item, runs
// down the same row, picks up the first qualifying cell and frees each cell
// as it passes, so the next set may start in the cycle right after tlast. The
// result passes through every cell and then the output register. Items past
// MAX_ITEMS in one set are dropped and flag overflow (found is then 0). A
// stalled result output holds the whole row, and the input with it.
module third_majority_element_finder_core #(
    parameter int MAX_ITEMS = tmef_pkg::MAX_ITEMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [31:0] item_value
    input  logic        i_s_axis_tlast,   // last_item
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] dominant_value
    output logic [1:0]  o_m_axis_tuser    // [0] found, [1] overflow
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    tmef_pkg::t_link  w_link  [MAX_ITEMS+1];
    logic [CNT_W-1:0] w_limit [MAX_ITEMS+1];
    logic             en;
    logic             acc;
    tmef_pkg::t_link  tail;

    logic                        r_out_vld;
    logic [tmef_pkg::DATA_W-1:0] r_out_value;
    logic                        r_out_found;
    logic                        r_out_ovf;

    // the row moves unless a finished result is waiting and not taken
    assign en  = !(r_out_vld && !i_m_axis_tready);
    assign acc = i_s_axis_tvalid && en;

    tmef_entry #(
        .MAX_ITEMS (MAX_ITEMS),
        .CNT_W     (CNT_W)
    ) u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_value (i_s_axis_tdata),
        .i_last  (i_s_axis_tlast),
        .o_link  (w_link[0]),
        .o_limit (w_limit[0])
    );

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        tmef_cell #(
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_link  (w_link[g]),
            .i_limit (w_limit[g]),
            .o_link  (w_link[g+1]),
            .o_limit (w_limit[g+1])
        );
    end

    assign tail = w_link[MAX_ITEMS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= tail.tok_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && tail.tok_vld) begin
            r_out_value <= tail.tok_value;
            r_out_found <= tail.tok_found;
            r_out_ovf   <= tail.tok_ovf;
        end
    end

    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = {r_out_ovf, r_out_found};

endmodule

@@ src/tmef_entry.sv @@
// Entry stage of the finder: counts the items of a set, drops overflow items,
// keeps floor(n/3) and launches the end-of-set request. Uses tmef_pkg.
module tmef_entry #(
    parameter int MAX_ITEMS = tmef_pkg::MAX_ITEMS_DEF,
    parameter int CNT_W     = $clog2(MAX_ITEMS + 1)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  logic [tmef_pkg::DATA_W-1:0] i_value,
    input  logic                      i_last,
    output tmef_pkg::t_link           o_link,
    output logic [CNT_W-1:0]          o_limit
);

    logic [CNT_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0] r_quo, n_quo;
    logic [1:0]       r_rem, n_rem;
    logic             r_ovf, n_ovf;
    logic             full;
    logic             take_item;
    logic [CNT_W-1:0] quo_upd;
    logic [1:0]       rem_upd;

    assign full      = (r_seen == CNT_W'(MAX_ITEMS));
    assign take_item = i_acc && !full;

    // floor(n/3) kept incrementally as quotient and remainder
    always_comb begin
        if (r_rem == 2'd2) begin
            rem_upd = 2'd0;
            quo_upd = r_quo + CNT_W'(1);
        end else begin
            rem_upd = r_rem + 2'd1;
            quo_upd = r_quo;
        end
    end

    always_comb begin
        n_seen = r_seen;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_ovf  = r_ovf;
        if (i_acc) begin
            if (take_item) begin
                n_seen = r_seen + CNT_W'(1);
                n_quo  = quo_upd;
                n_rem  = rem_upd;
            end else begin
                n_ovf = 1'b1;
            end
            if (i_last) begin
                n_seen = '0;
                n_quo  = '0;
                n_rem  = '0;
                n_ovf  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_quo  <= '0;
            r_rem  <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_seen <= n_seen;
            r_quo  <= n_quo;
            r_rem  <= n_rem;
            r_ovf  <= n_ovf;
        end
    end

    always_comb begin
        o_link.item_vld   = take_item;
        o_link.item_value = i_value;
        o_link.tok_vld    = i_acc && i_last;
        o_link.tok_found  = 1'b0;
        o_link.tok_ovf    = r_ovf || (i_acc && full);
        o_link.tok_value  = '0;
        o_limit           = take_item ? quo_upd : r_quo;
    end

endmodule

@@ src/tmef_cell.sv @@
// One match-and-count cell: holds a distinct value and its count, absorbs
// matching items, and updates the passing end-of-set request. Uses tmef_pkg.
module tmef_cell #(
    parameter int CNT_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  tmef_pkg::t_link  i_link,
    input  logic [CNT_W-1:0] i_limit,
    output tmef_pkg::t_link  o_link,
    output logic [CNT_W-1:0] o_limit
);

    logic                          r_occ, n_occ;
    logic [tmef_pkg::DATA_W-1:0]   r_val, n_val;
    logic [CNT_W-1:0]              r_cnt, n_cnt;
    tmef_pkg::t_link               r_link, n_link;
    logic [CNT_W-1:0]              r_limit;
    logic                          hit;
    logic                          take;
    logic                          qual;

    assign hit  = i_link.item_vld && r_occ && (r_val == i_link.item_value);
    assign take = i_link.item_vld && !r_occ;

    always_comb begin
        n_occ = r_occ || take;
        n_val = take ? i_link.item_value : r_val;
        if (take) begin
            n_cnt = CNT_W'(1);
        end else if (hit) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else begin
            n_cnt = r_cnt;
        end

        // the request sees this cell after any item riding with it
        qual = i_link.tok_vld && !i_link.tok_found && !i_link.tok_ovf
               && n_occ && (n_cnt > i_limit);

        n_link          = i_link;
        n_link.item_vld = i_link.item_vld && !hit && !take;
        if (qual) begin
            n_link.tok_found = 1'b1;
            n_link.tok_value = n_val;
        end

        // the set ends here: free the cell for the next one
        if (i_link.tok_vld) begin
            n_occ = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ           <= 1'b0;
            r_link.item_vld <= 1'b0;
            r_link.tok_vld  <= 1'b0;
        end else if (i_en) begin
            r_occ  <= n_occ;
            r_link <= n_link;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_val   <= n_val;
            r_cnt   <= n_cnt;
            r_limit <= i_limit;
        end
    end

    assign o_link  = r_link;
    assign o_limit = r_limit;

endmodule
